FILE: rtl/key_macro_record_replay_core_defines.svh
// ---------------------------------------------------------------------------
// key macro record/replay assertion macros
// shared property shapes for the checker, clocked on clock, reset on reset
// ---------------------------------------------------------------------------
`ifndef KEY_MACRO_RECORD_REPLAY_CORE_DEFINES_SVH
`define KEY_MACRO_RECORD_REPLAY_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define KMR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kmr: same-cycle check failed");

// next-cycle implication, off during reset
`define KMR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kmr: next-cycle check failed");

// next-cycle implication, also checked through reset
`define KMR_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("kmr: reset-time check failed");

`endif

FILE: rtl/kmr_pkg.sv
// ---------------------------------------------------------------------------
// kmr_pkg
// types, codes and default sizes of the key macro record/replay engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmr_pkg;

   localparam int KMR_SLOTS     = 4;
   localparam int KMR_ACTIONS   = 64;
   localparam int KMR_TICK_BITS = 32;
   localparam int MAX_RESULTS   = 64;
   localparam int KEY_BITS      = 16;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_KEY  = 2'd1;
   localparam logic [1:0] CMD_CTRL = 2'd2;

   localparam logic [3:0] CTRL_REC_START  = 4'd0;
   localparam logic [3:0] CTRL_REC_STOP   = 4'd1;
   localparam logic [3:0] CTRL_REC_TOGGLE = 4'd2;
   localparam logic [3:0] CTRL_ONCE       = 4'd3;
   localparam logic [3:0] CTRL_LOOP       = 4'd4;
   localparam logic [3:0] CTRL_ONCE_NOGAP = 4'd5;
   localparam logic [3:0] CTRL_LOOP_NOGAP = 4'd6;
   localparam logic [3:0] CTRL_STOP       = 4'd7;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_REC  = 2'd1,
      MODE_ONCE = 2'd2,
      MODE_LOOP = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CTRL,
      ST_REC,
      ST_SCAN,
      ST_EVAL,
      ST_REBASE,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/kmr_if.sv
// ---------------------------------------------------------------------------
// kmr channel interfaces
// valid/ready channels for request items and replayed key results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kmr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [1:0]  slot;
   logic [3:0]  control;
   logic [15:0] key_code;
   logic        key_down;

   modport source (output valid, cmd, slot, control, key_code, key_down, input ready);
   modport sink   (input valid, cmd, slot, control, key_code, key_down, output ready);
endinterface

interface kmr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_slot;
   logic [15:0] out_key;
   logic        out_down;
   logic        last;

   modport source (output valid, out_slot, out_key, out_down, last, input ready);
   modport sink   (input valid, out_slot, out_key, out_down, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/key_macro_record_replay_core.sv
// ---------------------------------------------------------------------------
// key_macro_record_replay_core
// multi-slot keyboard macro engine: records key events, replays them on ticks
// ---------------------------------------------------------------------------
// Recorded actions live in one single-port synchronous memory of
// SLOTS*ACTIONS entries (key, press flag, tick offset); slot modes, start
// ticks and positions are small per-slot registers. After reset the memory
// is swept clear, one entry a cycle, before the first request is taken.
// Every item goes through the one memory port in turn: a tick is accepted,
// each slot is scanned, with a read and an evaluation per replayed action
// (up to 64 per tick), and the results are flushed; a key event visits
// each slot in turn; a control command is applied, and a no-gap start
// then rebases from the first entry. A replayed action can sit in the output
// register while the engine moves on; once both the hold and the output
// register are full the tick waits on the receiver. The last result of a tick is marked.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_macro_record_replay_core
   import kmr_pkg::*;
#(
   parameter int SLOTS     = KMR_SLOTS,
   parameter int ACTIONS   = KMR_ACTIONS,
   parameter int TICK_BITS = KMR_TICK_BITS
) (
   input  logic      clock,
   input  logic      reset,
   kmr_req_if.sink   req_ch,
   kmr_rsp_if.source rsp_ch
);

   localparam int DEPTH      = SLOTS * ACTIONS;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int IDX_BITS   = $clog2(ACTIONS);
   localparam int POS_BITS   = $clog2(ACTIONS + 1);
   localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_RESULTS + 1);
   localparam int ENTRY_BITS = TICK_BITS + 1 + KEY_BITS;

   // control state
   state_type             state_ff, state_in;
   logic [SLOT_BITS-1:0]  cur_ff, cur_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [TICK_BITS-1:0]  tick_ff, tick_in;
   logic [ADDR_BITS-1:0]  clr_ff, clr_in;

   // captured request
   logic [1:0]            cmd_ff;
   logic [3:0]            ctrl_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic                  down_ff;

   // per-slot registers
   mode_type              slot_mode_ff  [SLOTS];
   logic [TICK_BITS-1:0]  slot_begin_ff [SLOTS];
   logic [POS_BITS-1:0]   slot_pos_ff   [SLOTS];
   logic                  slot_we;
   mode_type              slot_mode_in;
   logic [TICK_BITS-1:0]  slot_begin_in;
   logic [POS_BITS-1:0]   slot_pos_in;

   // action store
   logic [ENTRY_BITS-1:0] mem_q [DEPTH];
   logic [ENTRY_BITS-1:0] rd_ff;
   logic                  mem_we, mem_re;
   logic [ADDR_BITS-1:0]  mem_addr;
   logic [ENTRY_BITS-1:0] mem_wdata;

   // result path
   logic                  pend_valid_ff;
   logic [1:0]            pend_slot_ff;
   logic [KEY_BITS-1:0]   pend_key_ff;
   logic                  pend_down_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_slot_ff;
   logic [KEY_BITS-1:0]   rsp_key_ff;
   logic                  rsp_down_ff;
   logic                  rsp_last_ff;
   logic                  emit, flush_push, push, out_free, can_emit;

   // decoded views
   mode_type              cur_mode;
   logic [TICK_BITS-1:0]  cur_begin;
   logic [POS_BITS-1:0]   cur_pos;
   logic [IDX_BITS-1:0]   cur_idx;
   logic [ADDR_BITS-1:0]  row_base, entry_addr;
   logic [TICK_BITS-1:0]  rd_delay, rec_delay, due_diff;
   logic [KEY_BITS-1:0]   rd_key;
   logic                  rd_down;
   logic                  due, pos_end, last_slot, playing, slot_ok;
   logic [ENTRY_BITS-1:0] term_wdata;
   state_type             next_slot_state;
   logic [SLOT_BITS-1:0]  next_slot_cur;

   assign cur_mode   = slot_mode_ff[cur_ff];
   assign cur_begin  = slot_begin_ff[cur_ff];
   assign cur_pos    = slot_pos_ff[cur_ff];
   assign pos_end    = (cur_pos >= POS_BITS'(ACTIONS));
   assign cur_idx    = pos_end ? IDX_BITS'(ACTIONS - 1) : cur_pos[IDX_BITS-1:0];
   assign row_base   = ADDR_BITS'(ADDR_BITS'(cur_ff) * ADDR_BITS'(ACTIONS));
   assign entry_addr = row_base + ADDR_BITS'(cur_idx);

   assign rd_key     = rd_ff[KEY_BITS-1:0];
   assign rd_down    = rd_ff[KEY_BITS];
   assign rd_delay   = rd_ff[ENTRY_BITS-1:KEY_BITS+1];
   assign rec_delay  = tick_ff - cur_begin;
   assign due_diff   = tick_ff - cur_begin - rd_delay;
   assign due        = !due_diff[TICK_BITS-1];
   assign term_wdata = {rec_delay, 1'b0, KEY_BITS'(0)};

   assign playing    = (cur_mode == MODE_ONCE) || (cur_mode == MODE_LOOP);
   assign last_slot  = (cur_ff == SLOT_BITS'(SLOTS - 1));
   assign slot_ok    = (32'(req_ch.slot) < SLOTS);

   assign next_slot_state = last_slot ? ST_FLUSH : ST_SCAN;
   assign next_slot_cur   = last_slot ? cur_ff : cur_ff + SLOT_BITS'(1);

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign can_emit = !pend_valid_ff || out_free;
   assign push     = (emit && pend_valid_ff) || flush_push;

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_slot = rsp_slot_ff;
   assign rsp_ch.out_key  = rsp_key_ff;
   assign rsp_ch.out_down = rsp_down_ff;
   assign rsp_ch.last     = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cur_ff   <= '0;
         cnt_ff   <= '0;
         tick_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         cnt_ff   <= cnt_in;
         tick_ff  <= tick_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         cmd_ff  <= req_ch.cmd;
         ctrl_ff <= req_ch.control;
         key_ff  <= req_ch.key_code;
         down_ff <= req_ch.key_down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_mode_ff[i]  <= MODE_IDLE;
            slot_begin_ff[i] <= '0;
            slot_pos_ff[i]   <= '0;
         end
      end else if (slot_we) begin
         slot_mode_ff[cur_ff]  <= slot_mode_in;
         slot_begin_ff[cur_ff] <= slot_begin_in;
         slot_pos_ff[cur_ff]   <= slot_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_q[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem_q[mem_addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      tick_in       = tick_ff;
      clr_in        = clr_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = entry_addr;
      mem_wdata     = '0;
      slot_we       = 1'b0;
      slot_mode_in  = cur_mode;
      slot_begin_in = cur_begin;
      slot_pos_in   = cur_pos;
      emit          = 1'b0;
      flush_push    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + ADDR_BITS'(1);
            if (clr_ff == ADDR_BITS'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_ch.valid) begin
               unique case (req_ch.cmd)
                  CMD_TICK: begin
                     tick_in  = tick_ff + TICK_BITS'(1);
                     cur_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  CMD_KEY: begin
                     if (req_ch.key_code != '0) begin
                        cur_in   = '0;
                        state_in = ST_REC;
                     end
                  end
                  CMD_CTRL: begin
                     if (slot_ok) begin
                        cur_in   = SLOT_BITS'(req_ch.slot);
                        state_in = ST_CTRL;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_REC: begin
            if (cur_mode == MODE_REC) begin
               mem_we  = 1'b1;
               slot_we = 1'b1;
               if (cur_idx == IDX_BITS'(ACTIONS - 1)) begin
                  // slot full: terminator replaces the last entry
                  mem_wdata    = term_wdata;
                  slot_mode_in = MODE_IDLE;
                  slot_pos_in  = '0;
               end else begin
                  mem_wdata   = {rec_delay, down_ff, key_ff};
                  slot_pos_in = POS_BITS'(cur_idx) + POS_BITS'(1);
               end
            end
            if (last_slot) begin
               state_in = ST_IDLE;
            end else begin
               cur_in = cur_ff + SLOT_BITS'(1);
            end
         end

         ST_CTRL: begin
            state_in = ST_IDLE;
            unique case (ctrl_ff)
               CTRL_REC_START: begin
                  slot_we       = 1'b1;
                  slot_mode_in  = MODE_REC;
                  slot_begin_in = tick_ff;
                  slot_pos_in   = '0;
               end
               CTRL_REC_STOP: begin
                  mem_we       = 1'b1;
                  mem_wdata    = term_wdata;
                  slot_we      = 1'b1;
                  slot_mode_in = MODE_IDLE;
                  slot_pos_in  = '0;
               end
               CTRL_REC_TOGGLE: begin
                  if (cur_mode == MODE_IDLE) begin
                     slot_we       = 1'b1;
                     slot_mode_in  = MODE_REC;
                     slot_begin_in = tick_ff;
                     slot_pos_in   = '0;
                  end else if (cur_mode == MODE_REC) begin
                     mem_we       = 1'b1;
                     mem_wdata    = term_wdata;
                     slot_we      = 1'b1;
                     slot_mode_in = MODE_IDLE;
                     slot_pos_in  = '0;
                  end
               end
               CTRL_ONCE, CTRL_LOOP: begin
                  slot_we       = 1'b1;
                  slot_mode_in  = (ctrl_ff == CTRL_ONCE) ? MODE_ONCE : MODE_LOOP;
                  slot_begin_in = tick_ff;
                  slot_pos_in   = '0;
               end
               CTRL_ONCE_NOGAP, CTRL_LOOP_NOGAP: begin
                  // start tick follows from the first entry's offset
                  slot_we       = 1'b1;
                  slot_mode_in  = (ctrl_ff == CTRL_ONCE_NOGAP) ? MODE_ONCE : MODE_LOOP;
                  slot_begin_in = tick_ff;
                  slot_pos_in   = '0;
                  mem_re        = 1'b1;
                  mem_addr      = row_base;
                  state_in      = ST_REBASE;
               end
               CTRL_STOP: begin
                  slot_we       = 1'b1;
                  slot_mode_in  = MODE_IDLE;
                  slot_begin_in = tick_ff;
                  slot_pos_in   = '0;
               end
               default: ;
            endcase
         end

         ST_SCAN: begin
            if (!playing) begin
               state_in = next_slot_state;
               cur_in   = next_slot_cur;
            end else if (pos_end) begin
               // ran off the end of the slot: terminator due at once
               if (cur_mode == MODE_ONCE) begin
                  slot_we      = 1'b1;
                  slot_mode_in = MODE_IDLE;
                  state_in     = next_slot_state;
                  cur_in       = next_slot_cur;
               end else begin
                  slot_we     = 1'b1;
                  slot_pos_in = '0;
                  mem_re      = 1'b1;
                  mem_addr    = row_base;
                  state_in    = ST_REBASE;
               end
            end else begin
               mem_re   = 1'b1;
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (!due) begin
               state_in = next_slot_state;
               cur_in   = next_slot_cur;
            end else if (rd_key == '0) begin
               if (cur_mode == MODE_ONCE) begin
                  slot_we      = 1'b1;
                  slot_mode_in = MODE_IDLE;
                  state_in     = next_slot_state;
                  cur_in       = next_slot_cur;
               end else begin
                  slot_we     = 1'b1;
                  slot_pos_in = '0;
                  mem_re      = 1'b1;
                  mem_addr    = row_base;
                  state_in    = ST_REBASE;
               end
            end else if (can_emit) begin
               emit        = 1'b1;
               slot_we     = 1'b1;
               slot_pos_in = cur_pos + POS_BITS'(1);
               cnt_in      = cnt_ff + CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(MAX_RESULTS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_REBASE: begin
            slot_we       = 1'b1;
            slot_begin_in = tick_ff + rd_delay;
            if (cmd_ff == CMD_TICK) begin
               state_in = next_slot_state;
               cur_in   = next_slot_cur;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               flush_push = 1'b1;
               state_in   = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // one-deep hold so the final transfer of a tick can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (emit) begin
         pend_valid_ff <= 1'b1;
      end else if (flush_push) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pend_slot_ff <= 2'(cur_ff);
         pend_key_ff  <= rd_key;
         pend_down_ff <= rd_down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_slot_ff <= pend_slot_ff;
         rsp_key_ff  <= pend_key_ff;
         rsp_down_ff <= pend_down_ff;
         rsp_last_ff <= flush_push;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/kmr_checker.sv
// ---------------------------------------------------------------------------
// kmr_checker
// port-level checks of the key macro engine, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "key_macro_record_replay_core_defines.svh"

module kmr_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_out_slot,
   input wire [15:0] rsp_out_key,
   input wire        rsp_out_down,
   input wire        rsp_last
);

   // clearing sweep follows reset
   `KMR_ASSERT_NEXT_ALWAYS(a_clear_after_reset, reset, !req_ready)

   `KMR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_key) && $stable(rsp_out_slot) && $stable(rsp_out_down) && $stable(rsp_last))

   // a request transfer never produces a result in the very next cycle
   `KMR_ASSERT_NEXT(a_no_rsp_after_req, req_valid && req_ready, !$rose(rsp_valid))

   // no new request while a tick is still delivering results
   `KMR_ASSERT_SAME(a_busy_mid_tick, rsp_valid && !rsp_last, !req_ready)

   `KMR_ASSERT_SAME(a_key_nonzero, rsp_valid, rsp_out_key != 16'd0)

endmodule

bind key_macro_record_replay_core kmr_checker u_kmr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_slot (rsp_ch.out_slot),
   .rsp_out_key  (rsp_ch.out_key),
   .rsp_out_down (rsp_ch.out_down),
   .rsp_last     (rsp_ch.last)
);

`default_nettype wire
